### design/swap_slot_manager_defines.svh
// Assertion macros shared by the swap slot manager RTL.
`ifndef SWAP_SLOT_MANAGER_DEFINES_SVH
`define SWAP_SLOT_MANAGER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SSM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SSM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/ssm_pkg.sv
// Shared constants, codes and types of the swap slot manager.
package ssm_pkg;

	// Backing store geometry.
	localparam int NUM_BLOCKS = 4096;
	localparam int IDX_W      = $clog2(NUM_BLOCKS);
	localparam int KEY_W      = 64;
	localparam int BLK_W      = 12;
	localparam int S_TDATA_W  = 64;
	localparam int M_TDATA_W  = 16;

	// Request kinds.
	localparam logic CMD_SWAP_OUT = 1'b0;
	localparam logic CMD_SWAP_IN  = 1'b1;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_DUPLICATE = 2'd3
	} status_t;

	// Access to the slot table: one read and one write port.
	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		logic             wr_used;
		logic [KEY_W-1:0] wr_key;
	} mem_req_t;

	// Registered read data of the slot table.
	typedef struct packed {
		logic             used;
		logic [KEY_W-1:0] key;
	} mem_rsp_t;

endpackage

### design/ssm_slot_mem.sv
// Slot table: used flag and owner key per block, with a clearing pass after reset.
module ssm_slot_mem
	import ssm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  mem_req_t req,
	output mem_rsp_t rsp,
	output logic     ready
);

	logic [KEY_W:0]   mem [NUM_BLOCKS];
	logic [KEY_W:0]   rd_data_q;
	logic [IDX_W-1:0] clr_cnt_q;
	logic             clearing_q;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [KEY_W:0]   wr_data;

	// The clearing pass owns the write port until every used flag is zero.
	always_comb begin
		if (clearing_q) begin
			wr_en   = 1'b1;
			wr_addr = clr_cnt_q;
			wr_data = '0;
		end else begin
			wr_en   = req.wr_en;
			wr_addr = req.wr_addr;
			wr_data = {req.wr_used, req.wr_key};
		end
	end

	// Clearing sweep, one entry per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q  <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == IDX_W'(NUM_BLOCKS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// Storage array with registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_addr];
		end
	end

	assign rsp.used = rd_data_q[KEY_W];
	assign rsp.key  = rd_data_q[KEY_W-1:0];
	assign ready    = !clearing_q;

endmodule

### design/swap_slot_manager.sv
// Top level of the swap slot manager: request sequencer around the slot table.
//
// Each request scans the whole slot table of NUM_BLOCKS entries through the
// table's single read port, one entry per cycle, then writes back and loads the
// result, which waits while the output register still holds an unaccepted one;
// only then can the next request be taken. A swap-out takes the lowest free
// block and records the key (refused when the store is full or the key is
// already held); a swap-in frees the lowest block that holds the key. After
// reset a clearing pass marks every block free, and no request is accepted until it
// ends. A finished result waits in an output register, so the next request may
// start while it is still pending.
`include "swap_slot_manager_defines.svh"

module swap_slot_manager
	import ssm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // [63:0] page_key
	input  logic                 s_tuser,   // [0] command
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // [11:0] block_number, [15:12] zero
	output logic [1:0]           m_tuser    // [1:0] status
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	state_t           state_q;
	mem_req_t         mem_req;
	mem_rsp_t         mem_rsp;
	logic             mem_ready;

	logic             issuing_q;
	logic [IDX_W-1:0] cnt_q;
	logic             valid_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             free_found_q;
	logic [IDX_W-1:0] free_idx_q;
	logic             hit_found_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic             cmd_q;
	logic [KEY_W-1:0] key_q;
	logic             out_valid_q;
	status_t          out_status_q;
	logic [BLK_W-1:0] out_blk_q;

	logic             in_accept;
	logic             out_load;
	status_t          res_status;
	logic [IDX_W-1:0] res_idx;

	ssm_slot_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.rsp    (mem_rsp),
		.ready  (mem_ready)
	);

	assign s_tready  = (state_q == S_IDLE) && mem_ready;
	assign in_accept = s_tvalid && s_tready;
	assign out_load  = (state_q == S_FINISH) && (!out_valid_q || m_tready);

	// Decide the outcome from the scan results.
	always_comb begin
		res_status = ST_OK;
		res_idx    = free_idx_q;
		if (cmd_q == CMD_SWAP_OUT) begin
			priority if (!free_found_q) begin
				res_status = ST_FULL;
			end else if (hit_found_q) begin
				res_status = ST_DUPLICATE;
			end else begin
				res_status = ST_OK;
			end
		end else begin
			res_idx    = hit_idx_q;
			res_status = hit_found_q ? ST_OK : ST_NOT_FOUND;
		end
	end

	// Table accesses: scan reads, then one write-back on success.
	always_comb begin
		mem_req.rd_en   = (state_q == S_SCAN) && issuing_q;
		mem_req.rd_addr = cnt_q;
		mem_req.wr_en   = out_load && (res_status == ST_OK);
		mem_req.wr_addr = res_idx;
		mem_req.wr_used = (cmd_q == CMD_SWAP_OUT);
		mem_req.wr_key  = key_q;
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			issuing_q    <= 1'b0;
			cnt_q        <= '0;
			valid_s1     <= 1'b0;
			free_found_q <= 1'b0;
			hit_found_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			valid_s1 <= mem_req.rd_en;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						state_q      <= S_SCAN;
						issuing_q    <= 1'b1;
						cnt_q        <= '0;
						free_found_q <= 1'b0;
						hit_found_q  <= 1'b0;
					end
				end
				S_SCAN: begin
					if (issuing_q) begin
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == IDX_W'(NUM_BLOCKS - 1)) begin
							issuing_q <= 1'b0;
						end
					end
					if (valid_s1) begin
						if (!mem_rsp.used && !free_found_q) begin
							free_found_q <= 1'b1;
						end
						if (mem_rsp.used && (mem_rsp.key == key_q) && !hit_found_q) begin
							hit_found_q <= 1'b1;
						end
						if (idx_s1 == IDX_W'(NUM_BLOCKS - 1)) begin
							state_q <= S_FINISH;
						end
					end
				end
				S_FINISH: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers: request, scan indexes and result.
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		if (in_accept) begin
			cmd_q <= s_tuser;
			key_q <= s_tdata;
		end
		if ((state_q == S_SCAN) && valid_s1) begin
			if (!mem_rsp.used && !free_found_q) begin
				free_idx_q <= idx_s1;
			end
			if (mem_rsp.used && (mem_rsp.key == key_q) && !hit_found_q) begin
				hit_idx_q <= idx_s1;
			end
		end
		if (out_load) begin
			out_status_q <= res_status;
			out_blk_q    <= (res_status == ST_OK) ? BLK_W'(res_idx) : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {{(M_TDATA_W - BLK_W){1'b0}}, out_blk_q};

	`SSM_ASSERT_NOW(a_no_write_in_scan, state_q == S_SCAN, !mem_req.wr_en, "table written during a scan")
	`SSM_ASSERT_NOW(a_accept_after_clear, in_accept, mem_ready, "request taken before clearing ended")
	`SSM_ASSERT_NEXT(a_accept_starts_scan, in_accept, state_q == S_SCAN && issuing_q && cnt_q == '0, "scan did not start")
	`SSM_ASSERT_NOW(a_fail_zero_block, out_valid_q && out_status_q != ST_OK, out_blk_q == '0, "failed result carries a block")

endmodule

### test/swap_slot_manager_tb.sv
// Self-checking testbench for the swap slot manager: directed table, then random swap traffic.
module swap_slot_manager_tb;
	import ssm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// One result word: status and block number.
	typedef struct {
		status_t          status;
		logic [BLK_W-1:0] blk;
	} slot_result_t;

	// One row of the directed table; typed rows carry their own expected result.
	typedef struct {
		logic             cmd;
		logic [KEY_W-1:0] key;
		bit               typed;
		status_t          status;
		logic [BLK_W-1:0] blk;
	} dir_row_t;

	localparam int RAND_WORDS = 122;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;   // [63:0] page_key
	logic                 s_tuser  = 1'b0; // [0] command
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;         // [11:0] block_number, [15:12] zero
	logic [1:0]           m_tuser;         // [1:0] status

	// Shadow copy of the slot table used for prediction.
	bit               shadow_used [NUM_BLOCKS];
	logic [KEY_W-1:0] shadow_key  [NUM_BLOCKS];

	slot_result_t     pending_q[$];
	logic [KEY_W-1:0] held_keys[$];
	logic [KEY_W-1:0] freed_keys[$];
	int               err_count = 0;
	bit               idle_on   = 1'b1;
	int               stall_left = 0;

	// Filling all 4096 blocks would make the run too long, so the
	// full-store case is covered by the shadow table only.
	dir_row_t dir_rows [18] = '{
		'{CMD_SWAP_OUT, 64'h0000_0000_0000_0000, 1'b1, ST_OK,        12'd0},
		'{CMD_SWAP_OUT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_OK,        12'd1},
		'{CMD_SWAP_OUT, 64'h0000_0000_0000_0000, 1'b1, ST_DUPLICATE, 12'd0},
		'{CMD_SWAP_IN,  64'h0000_0000_0000_0001, 1'b1, ST_NOT_FOUND, 12'd0},
		'{CMD_SWAP_IN,  64'h0000_0000_0000_0000, 1'b1, ST_OK,        12'd0},
		'{CMD_SWAP_IN,  64'h0000_0000_0000_0000, 1'b1, ST_NOT_FOUND, 12'd0},
		'{CMD_SWAP_OUT, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, ST_OK,        12'd0},
		'{CMD_SWAP_OUT, 64'h5555_5555_5555_5555, 1'b0, ST_OK,        12'd0},
		'{CMD_SWAP_OUT, 64'h8000_0000_0000_0000, 1'b0, ST_OK,        12'd0},
		'{CMD_SWAP_IN,  64'hFFFF_FFFF_FFFF_FFFE, 1'b1, ST_NOT_FOUND, 12'd0},
		'{CMD_SWAP_IN,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, ST_OK,        12'd0},
		'{CMD_SWAP_OUT, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, ST_OK,        12'd0},
		'{CMD_SWAP_OUT, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, ST_DUPLICATE, 12'd0},
		'{CMD_SWAP_IN,  64'h5555_5555_5555_5555, 1'b0, ST_OK,        12'd0},
		'{CMD_SWAP_IN,  64'hAAAA_AAAA_AAAA_AAAA, 1'b0, ST_OK,        12'd0},
		'{CMD_SWAP_OUT, 64'h0000_0000_0000_0001, 1'b0, ST_OK,        12'd0},
		'{CMD_SWAP_IN,  64'h8000_0000_0000_0000, 1'b0, ST_OK,        12'd0},
		'{CMD_SWAP_OUT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, ST_OK,        12'd0}
	};

	swap_slot_manager u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #2 clk = ~clk;

	// Applies one request to the shadow table and returns the result it gives.
	function automatic slot_result_t swap_slot(input logic cmd, input logic [KEY_W-1:0] key);
		slot_result_t res;
		int           free_blk;
		int           owner_blk;
		free_blk  = NUM_BLOCKS;
		owner_blk = NUM_BLOCKS;
		for (int b = NUM_BLOCKS - 1; b >= 0; b--) begin
			if (!shadow_used[b])
				free_blk = b;
			else if (shadow_key[b] == key)
				owner_blk = b;
		end
		res.blk = '0;
		if (cmd == CMD_SWAP_OUT) begin
			// A full store is reported before a duplicate key.
			if (free_blk == NUM_BLOCKS) begin
				res.status = ST_FULL;
			end else if (owner_blk != NUM_BLOCKS) begin
				res.status = ST_DUPLICATE;
			end else begin
				shadow_used[free_blk] = 1'b1;
				shadow_key[free_blk]  = key;
				res.status = ST_OK;
				res.blk    = BLK_W'(free_blk);
			end
		end else begin
			if (owner_blk == NUM_BLOCKS) begin
				res.status = ST_NOT_FOUND;
			end else begin
				shadow_used[owner_blk] = 1'b0;
				res.status = ST_OK;
				res.blk    = BLK_W'(owner_blk);
			end
		end
		return res;
	endfunction

	// Random page key, biased toward the extremes and one-hot values.
	function automatic logic [KEY_W-1:0] pick_key();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2:       return 64'd1 << $urandom_range(0, 63);
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	// Sends one request word and records what it should produce.
	task automatic send_word(input logic cmd, input logic [KEY_W-1:0] key, input bit typed,
			input slot_result_t typed_res);
		slot_result_t res;
		int           gap;
		@(negedge clk);
		if (idle_on && $urandom_range(0, 2) == 0) begin
			gap = $urandom_range(1, 10);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= key;
		s_tuser  <= cmd;
		do @(posedge clk); while (!s_tready);
		res = swap_slot(cmd, key);
		pending_q.push_back(typed ? typed_res : res);
		// Keep the lists of held and released keys that random traffic draws on.
		if (res.status == ST_OK) begin
			if (cmd == CMD_SWAP_OUT) begin
				held_keys.push_back(key);
			end else begin
				foreach (held_keys[i]) begin
					if (held_keys[i] == key) begin
						held_keys.delete(i);
						break;
					end
				end
				freed_keys.push_back(key);
			end
		end
	endtask

	// Drops valid and holds the sender until every result is back.
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (pending_q.size() == 0);
	endtask

	// Result receiver: ready with random stall bursts.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 9);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Compare every accepted result word with the oldest expectation.
	always @(posedge clk) begin
		slot_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_q.size() == 0) begin
				$error("unexpected result word: status %0d block %0d", m_tuser, m_tdata[11:0]);
				err_count++;
			end else begin
				want = pending_q.pop_front();
				if (m_tuser !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_tuser);
					err_count++;
				end
				if (m_tdata[BLK_W-1:0] !== want.blk) begin
					$error("block_number: expected %0d, got %0d", want.blk, m_tdata[BLK_W-1:0]);
					err_count++;
				end
				if (m_tdata[M_TDATA_W-1:BLK_W] !== '0) begin
					$error("m_tdata pad: expected 0, got %0h", m_tdata[M_TDATA_W-1:BLK_W]);
					err_count++;
				end
			end
		end
	end

	// Main sequence: reset, directed table, random traffic, drain.
	initial begin
		slot_result_t     typed_res;
		logic [KEY_W-1:0] key;
		int               pick;
		int               idx;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			typed_res.status = dir_rows[i].status;
			typed_res.blk    = dir_rows[i].blk;
			send_word(dir_rows[i].cmd, dir_rows[i].key, dir_rows[i].typed, typed_res);
		end
		drain_results();

		// Mostly matched swap-out and swap-in pairs, with refused requests mixed in.
		for (int n = 0; n < RAND_WORDS; n++) begin
			if (n == RAND_WORDS / 2)
				drain_results();
			if (n == RAND_WORDS * 4 / 5)
				idle_on = 1'b0;
			pick = $urandom_range(0, 99);
			if (pick < 45 || held_keys.size() == 0) begin
				send_word(CMD_SWAP_OUT, pick_key(), 1'b0, typed_res);
			end else if (pick < 78) begin
				idx = $urandom_range(0, held_keys.size() - 1);
				send_word(CMD_SWAP_IN, held_keys[idx], 1'b0, typed_res);
			end else if (pick < 87) begin
				idx = $urandom_range(0, held_keys.size() - 1);
				send_word(CMD_SWAP_OUT, held_keys[idx], 1'b0, typed_res);
			end else if (pick < 93 && freed_keys.size() != 0) begin
				idx = $urandom_range(0, freed_keys.size() - 1);
				send_word(CMD_SWAP_IN, freed_keys[idx], 1'b0, typed_res);
			end else begin
				// A held key with one bit flipped, or a fresh random key.
				idx = $urandom_range(0, held_keys.size() - 1);
				key = ($urandom_range(0, 1) != 0)
					? (held_keys[idx] ^ (64'd1 << $urandom_range(0, 63))) : pick_key();
				send_word(CMD_SWAP_IN, key, 1'b0, typed_res);
			end
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (pending_q.size() == 0);
		repeat (NUM_BLOCKS + 16) @(posedge clk);
		if (err_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Watchdog.
	initial begin
		#15ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule
